@@ hw/rtl/ocavg_pkg.sv @@
`default_nettype none

package ocavg_pkg;

  // Fixed field widths.
  localparam int unsigned SAMPLE_IN_W = 12;
  localparam int unsigned OFFSET_W    = 12;
  localparam int unsigned CURRENT_W   = 16;
  localparam int unsigned SCALE_W     = 16;
  localparam int unsigned SCALE_FRAC  = 12;

  // Scale of 5.6865 in unsigned Q4.12.
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd23292;

  // Saturation limits of the signed current result.
  localparam logic [CURRENT_W-1:0] CURRENT_MAX = 16'h7FFF;
  localparam logic [CURRENT_W-1:0] CURRENT_MIN = 16'h8000;
  localparam int unsigned CURRENT_POS_LIM = 32767;
  localparam int unsigned CURRENT_NEG_LIM = 32768;

  // Shift control shared by every cell of the sample chain.
  typedef struct packed {
    logic push;  // a request was accepted, shift the chain
    logic dbl;   // two samples enter: shift by two places
  } push_t;

endpackage

`default_nettype wire

@@ hw/rtl/ocavg_cell.sv @@
`default_nettype none

module ocavg_cell #(
  parameter int unsigned W = 12
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  ocavg_pkg::push_t  ctl_i,
  input  wire  [W-1:0]      d1_i,
  input  wire  [W-1:0]      d2_i,
  output logic [W-1:0]      q_o,
  output logic [W-1:0]      d1_o
);
  import ocavg_pkg::*;

  logic [W-1:0] smp_q;
  logic [W-1:0] smp_d;

  always_comb begin
    smp_d = smp_q;
    if (ctl_i.push) begin
      smp_d = ctl_i.dbl ? d2_i : d1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_q <= '0;
    end else begin
      smp_q <= smp_d;
    end
  end

  assign q_o  = smp_q;
  // The sample one place upstream is passed on, so a cell two places down
  // can take it on a double shift.
  assign d1_o = d1_i;

endmodule

`default_nettype wire

@@ hw/rtl/ocavg_ring.sv @@
`default_nettype none

module ocavg_ring #(
  parameter int unsigned TAPS  = 10,
  parameter int unsigned W     = 12,
  parameter int unsigned SUM_W = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  ocavg_pkg::push_t    ctl_i,
  input  wire  [W-1:0]        first_i,
  input  wire  [W-1:0]        second_i,
  output logic [SUM_W-1:0]    sum1_o,
  output logic [SUM_W-1:0]    sum2_o
);
  import ocavg_pkg::*;

  logic [W-1:0]     cell_q  [TAPS];
  logic [W-1:0]     cell_fw [TAPS];
  logic [SUM_W-1:0] sum_q;
  logic [SUM_W-1:0] sum_d;

  // The newest sample sits in cell 0; the last cell holds the oldest one.
  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    if (i == 0) begin : g_head
      ocavg_cell #(.W(W)) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctl_i  (ctl_i),
        .d1_i   (first_i),
        .d2_i   (second_i),
        .q_o    (cell_q[i]),
        .d1_o   (cell_fw[i])
      );
    end else begin : g_body
      ocavg_cell #(.W(W)) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctl_i  (ctl_i),
        .d1_i   (cell_q[i-1]),
        .d2_i   (cell_fw[i-1]),
        .q_o    (cell_q[i]),
        .d1_o   (cell_fw[i])
      );
    end
  end

  // A double shift drops the last cell and then the one before it; with a
  // single tap the second drop is the first sample of the same request.
  assign sum1_o = sum_q - SUM_W'(cell_q[TAPS-1]) + SUM_W'(first_i);
  assign sum2_o = sum1_o - SUM_W'(cell_fw[TAPS-1]) + SUM_W'(second_i);

  always_comb begin
    sum_d = sum_q;
    if (ctl_i.push) begin
      sum_d = ctl_i.dbl ? sum2_o : sum1_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

`ifndef SYNTHESIS
  a_head_takes_newest : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.push |=> cell_q[0] == $past(ctl_i.dbl ? second_i : first_i))
    else $error("newest sample not in the head cell");

  a_sum_holds_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl_i.push |=> $stable(sum_q))
    else $error("running sum moved without a push");

  a_tail_steps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.push && !ctl_i.dbl |=> cell_q[TAPS-1] == $past(cell_fw[TAPS-1]))
    else $error("sample chain did not step by one");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/offset_compensated_current_average_unit.sv @@
// Channel  | Handshake               | Payload
// -------- | ----------------------- | -----------------------------------------------
// in       | in_valid_i / in_ready_o | output_on_i, first_sample_i, second_sample_i
// out      | out_valid_o/out_ready_i | current_value_o, offset_level_o, average_level_o,
//          |                         | drive_on_o
// cfg      | cfg_we_i                | cfg_wdata_i (scale, Q4.12)
//
// One request is taken per cycle while in_ready_o is high.
// The sample chain and running sum update at the accepting edge; the two divides by TAPS
// (reciprocal multiplies), the offset subtract and the scale multiply follow in four stages.
// Reset clears the chain, the sum and the offset and loads the default scale at once.
// A stall at the output only holds stages that are full; empty stages still fill.
`default_nettype none

module offset_compensated_current_average_unit #(
  parameter int unsigned TAPS        = 10,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  input  wire                                       cfg_we_i,
  input  wire         [ocavg_pkg::SCALE_W-1:0]      cfg_wdata_i,
  input  wire                                       in_valid_i,
  output logic                                      in_ready_o,
  input  wire                                       output_on_i,
  input  wire         [ocavg_pkg::SAMPLE_IN_W-1:0]  first_sample_i,
  input  wire         [ocavg_pkg::SAMPLE_IN_W-1:0]  second_sample_i,
  output logic                                      out_valid_o,
  input  wire                                       out_ready_i,
  output logic signed [ocavg_pkg::CURRENT_W-1:0]    current_value_o,
  output logic        [ocavg_pkg::OFFSET_W-1:0]     offset_level_o,
  output logic        [ocavg_pkg::OFFSET_W-1:0]     average_level_o,
  output logic                                      drive_on_o
);
  import ocavg_pkg::*;

  localparam int unsigned EXT_W  = (SAMPLE_BITS > SAMPLE_IN_W) ? SAMPLE_BITS : SAMPLE_IN_W;
  localparam int unsigned SUM_W  = $clog2(TAPS * ((1 << SAMPLE_BITS) - 1) + 1);
  localparam int unsigned DIV_L  = $clog2(TAPS);
  localparam int unsigned DIV_S  = SUM_W + DIV_L;
  localparam int unsigned RCP_W  = SUM_W + 1;
  localparam longint unsigned RCP = ((64'd1 << DIV_S) + TAPS - 1) / TAPS;
  localparam int unsigned QP_W   = SUM_W + RCP_W;
  localparam int unsigned PRD_W  = EXT_W + SCALE_W;
  localparam int unsigned SCL_W  = PRD_W - SCALE_FRAC;

  // Configuration.
  logic [SCALE_W-1:0] scale_q;

  // Input masking to the filter's sample width.
  logic                   in_accept;
  logic [EXT_W-1:0]       first_ext;
  logic [EXT_W-1:0]       second_ext;
  push_t                  push;
  logic [SUM_W-1:0]       sum1;
  logic [SUM_W-1:0]       sum2;

  // Stage load enables, from the output backwards.
  logic ld_out, ld4, ld3, ld2, ld1;

  // Stage 1: sums after the first and the second push.
  logic             s1_valid_q;
  logic             s1_on_q;
  logic [SUM_W-1:0] s1_sum1_q;
  logic [SUM_W-1:0] s1_sum2_q;

  // Stage 2: reciprocal products.
  logic             s2_valid_q;
  logic             s2_on_q;
  logic [QP_W-1:0]  s2_avg_prod_q;
  logic [QP_W-1:0]  s2_off_prod_q;

  // Stage 3: offset subtract.
  logic                 s3_valid_q;
  logic                 s3_on_q;
  logic                 s3_neg_q;
  logic [EXT_W-1:0]     s3_mag_q;
  logic [OFFSET_W-1:0]  s3_avg_q;
  logic [OFFSET_W-1:0]  s3_off_q;
  logic [OFFSET_W-1:0]  zero_offset_q;

  logic [EXT_W-1:0]     avg_ext;
  logic [EXT_W-1:0]     off_ext;
  logic [OFFSET_W-1:0]  offset_new;
  logic signed [EXT_W:0] diff;

  // Stage 4: scale multiply.
  logic                 s4_valid_q;
  logic                 s4_on_q;
  logic                 s4_neg_q;
  logic [PRD_W-1:0]     s4_prod_q;
  logic [OFFSET_W-1:0]  s4_avg_q;
  logic [OFFSET_W-1:0]  s4_off_q;

  // Output register.
  logic                 out_valid_q;
  logic [CURRENT_W-1:0] cur_q;
  logic [CURRENT_W-1:0] cur_d;
  logic [OFFSET_W-1:0]  out_avg_q;
  logic [OFFSET_W-1:0]  out_off_q;
  logic                 out_on_q;
  logic [SCL_W-1:0]     scaled;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  assign ld_out     = !out_valid_q || out_ready_i;
  assign ld4        = !s4_valid_q || ld_out;
  assign ld3        = !s3_valid_q || ld4;
  assign ld2        = !s2_valid_q || ld3;
  assign ld1        = !s1_valid_q || ld2;
  assign in_ready_o = ld1;
  assign in_accept  = in_valid_i && in_ready_o;

  assign first_ext  = EXT_W'(first_sample_i);
  assign second_ext = EXT_W'(second_sample_i);
  assign push.push  = in_accept;
  assign push.dbl   = !output_on_i;

  ocavg_ring #(
    .TAPS  (TAPS),
    .W     (SAMPLE_BITS),
    .SUM_W (SUM_W)
  ) u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (push),
    .first_i  (first_ext[SAMPLE_BITS-1:0]),
    .second_i (second_ext[SAMPLE_BITS-1:0]),
    .sum1_o   (sum1),
    .sum2_o   (sum2)
  );

  // Stage 3 arithmetic: quotients out of the reciprocal products.
  assign avg_ext    = EXT_W'(s2_avg_prod_q[DIV_S +: SAMPLE_BITS]);
  assign off_ext    = EXT_W'(s2_off_prod_q[DIV_S +: SAMPLE_BITS]);
  assign offset_new = s2_on_q ? zero_offset_q : off_ext[OFFSET_W-1:0];
  assign diff       = $signed({1'b0, avg_ext}) - $signed({1'b0, EXT_W'(offset_new)});

  // Output arithmetic: drop the fraction and saturate toward the signed range.
  assign scaled = s4_prod_q[PRD_W-1:SCALE_FRAC];

  always_comb begin
    if (s4_neg_q) begin
      if (scaled > SCL_W'(CURRENT_NEG_LIM)) begin
        cur_d = CURRENT_MIN;
      end else begin
        cur_d = -scaled[CURRENT_W-1:0];
      end
    end else begin
      if (scaled > SCL_W'(CURRENT_POS_LIM)) begin
        cur_d = CURRENT_MAX;
      end else begin
        cur_d = scaled[CURRENT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      s2_valid_q    <= 1'b0;
      s3_valid_q    <= 1'b0;
      s4_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      zero_offset_q <= '0;
    end else begin
      if (ld1) begin
        s1_valid_q <= in_accept;
      end
      if (ld2) begin
        s2_valid_q <= s1_valid_q;
      end
      if (ld3) begin
        s3_valid_q <= s2_valid_q;
        if (s2_valid_q && !s2_on_q) begin
          zero_offset_q <= offset_new;
        end
      end
      if (ld4) begin
        s4_valid_q <= s3_valid_q;
      end
      if (ld_out) begin
        out_valid_q <= s4_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_on_q   <= output_on_i;
      s1_sum1_q <= sum1;
      s1_sum2_q <= sum2;
    end
    if (ld2 && s1_valid_q) begin
      s2_on_q       <= s1_on_q;
      s2_avg_prod_q <= QP_W'(s1_on_q ? s1_sum1_q : s1_sum2_q) * QP_W'(RCP_W'(RCP));
      s2_off_prod_q <= QP_W'(s1_sum1_q) * QP_W'(RCP_W'(RCP));
    end
    if (ld3 && s2_valid_q) begin
      s3_on_q  <= s2_on_q;
      s3_neg_q <= diff[EXT_W];
      s3_mag_q <= diff[EXT_W] ? EXT_W'(-diff) : diff[EXT_W-1:0];
      s3_avg_q <= avg_ext[OFFSET_W-1:0];
      s3_off_q <= offset_new;
    end
    if (ld4 && s3_valid_q) begin
      s4_on_q   <= s3_on_q;
      s4_neg_q  <= s3_neg_q;
      s4_prod_q <= PRD_W'(s3_mag_q) * PRD_W'(scale_q);
      s4_avg_q  <= s3_avg_q;
      s4_off_q  <= s3_off_q;
    end
    if (ld_out && s4_valid_q) begin
      cur_q     <= cur_d;
      out_avg_q <= s4_avg_q;
      out_off_q <= s4_off_q;
      out_on_q  <= s4_on_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign current_value_o = $signed(cur_q);
  assign offset_level_o  = out_off_q;
  assign average_level_o = out_avg_q;
  assign drive_on_o      = out_on_q;

`ifndef SYNTHESIS
  a_offset_only_when_off : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(zero_offset_q) |-> $past(ld3 && s2_valid_q && !s2_on_q))
    else $error("zero offset changed without an output-off request");

  a_stage1_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !ld2 |=> s1_valid_q)
    else $error("stage 1 request lost during a stall");

  a_result_from_stage4 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s4_valid_q))
    else $error("result appeared without a request in the last stage");

  a_stall_means_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && s2_valid_q && s3_valid_q && s4_valid_q && out_valid_q)
    else $error("input stalled while the pipeline has a free slot");
`endif

endmodule

`default_nettype wire
